FILE: rtl/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

   // Field and intermediate widths of the rotation datapath.
   localparam int IN_W  = 16;   // quaternion parts and vector components
   localparam int SQ_W  = 32;   // 16 x 16 signed products
   localparam int DEN_W = 33;   // squared norm, at most 2^32
   localparam int T_W   = 34;   // components of q * (0, v)
   localparam int RP_W  = 50;   // second level products
   localparam int R_W   = 52;   // vector part of the full product
   localparam int NUM_W = 53;   // rounded dividend 2*|r| + den
   localparam int DIV_W = 34;   // divisor 2*den
   localparam int QUO_W = 17;   // quotient bits resolved by the divider
   localparam int LANES = 3;

   localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
   localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);
   localparam logic [IN_W-1:0]  POS_CLIP  = 16'h7FFF;
   localparam logic [IN_W-1:0]  NEG_CLIP  = 16'h8000;

   typedef logic signed [IN_W-1:0] s16_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      logic [DIV_W-1:0]         dvs;
      logic                     zq;
   } div_stage_type;

endpackage

FILE: rtl/quaternion_vector_rotate_unit.sv
`timescale 1ns / 1ps
// A request is accepted at a rising edge, which loads the first of 23 register stages
// (four multiply and sum stages, one setup stage, 17 divider stages, output); the output
// stage drives the result on the rsp_ ports. Throughput: one request per cycle while no
// stall holds the pipeline; the restoring divider resolves one quotient bit per stage.
// A stall only holds the stages that cannot move; bubbles ahead of it still close up.
// Reset is synchronous and active high; it clears all valid bits, payload is not reset.
module quaternion_vector_rotate_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qvr_pkg::s16_type req_quat_s,
   input  qvr_pkg::s16_type req_quat_x,
   input  qvr_pkg::s16_type req_quat_y,
   input  qvr_pkg::s16_type req_quat_z,
   input  qvr_pkg::s16_type req_vec_x,
   input  qvr_pkg::s16_type req_vec_y,
   input  qvr_pkg::s16_type req_vec_z,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qvr_pkg::s16_type rsp_rot_x,
   output qvr_pkg::s16_type rsp_rot_y,
   output qvr_pkg::s16_type rsp_rot_z,
   output logic             rsp_zero_quat,
   output logic             rsp_saturated
);
   import qvr_pkg::*;

   // Every stage loads when it is empty or when the stage after it loads.
   // The chain ends at the output register, so a waiting result does not
   // block requests as long as some stage in front of it is empty.
   logic rdy_out;
   logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
   logic [QUO_W:0] rdy_div;

   // ---------------------------------------------------------------------
   // Stage 1: squares of the quaternion and the products of q * (0, v).
   // The zero quaternion flag is taken straight from the request.
   // ---------------------------------------------------------------------
   logic s1_vld_ff;
   logic s1_zq_ff, s1_zq_in;
   logic signed [SQ_W-1:0] sq_s_ff, sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [SQ_W-1:0] p_xvx_ff, p_yvy_ff, p_zvz_ff;
   logic signed [SQ_W-1:0] p_svx_ff, p_yvz_ff, p_zvy_ff;
   logic signed [SQ_W-1:0] p_svy_ff, p_zvx_ff, p_xvz_ff;
   logic signed [SQ_W-1:0] p_svz_ff, p_xvy_ff, p_yvx_ff;
   s16_type s1_qs_ff, s1_qx_ff, s1_qy_ff, s1_qz_ff;

   assign s1_zq_in = (req_quat_s == '0) && (req_quat_x == '0) &&
                     (req_quat_y == '0) && (req_quat_z == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (rdy_s1) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s1) begin
         s1_zq_ff <= s1_zq_in;
         sq_s_ff  <= req_quat_s * req_quat_s;
         sq_x_ff  <= req_quat_x * req_quat_x;
         sq_y_ff  <= req_quat_y * req_quat_y;
         sq_z_ff  <= req_quat_z * req_quat_z;
         p_xvx_ff <= req_quat_x * req_vec_x;
         p_yvy_ff <= req_quat_y * req_vec_y;
         p_zvz_ff <= req_quat_z * req_vec_z;
         p_svx_ff <= req_quat_s * req_vec_x;
         p_yvz_ff <= req_quat_y * req_vec_z;
         p_zvy_ff <= req_quat_z * req_vec_y;
         p_svy_ff <= req_quat_s * req_vec_y;
         p_zvx_ff <= req_quat_z * req_vec_x;
         p_xvz_ff <= req_quat_x * req_vec_z;
         p_svz_ff <= req_quat_s * req_vec_z;
         p_xvy_ff <= req_quat_x * req_vec_y;
         p_yvx_ff <= req_quat_y * req_vec_x;
         s1_qs_ff <= req_quat_s;
         s1_qx_ff <= req_quat_x;
         s1_qy_ff <= req_quat_y;
         s1_qz_ff <= req_quat_z;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: squared norm and the four parts of t = q * (0, v).
   // ---------------------------------------------------------------------
   logic s2_vld_ff;
   logic s2_zq_ff;
   logic [DEN_W-1:0] s2_den_ff, s2_den_in;
   logic signed [T_W-1:0] t_s_ff, t_x_ff, t_y_ff, t_z_ff;
   logic signed [T_W-1:0] t_s_in, t_x_in, t_y_in, t_z_in;
   s16_type s2_qs_ff, s2_qx_ff, s2_qy_ff, s2_qz_ff;

   // The squares are never negative, so their bit patterns add as unsigned.
   assign s2_den_in = DEN_W'(unsigned'(sq_s_ff)) + DEN_W'(unsigned'(sq_x_ff)) +
                      DEN_W'(unsigned'(sq_y_ff)) + DEN_W'(unsigned'(sq_z_ff));
   assign t_s_in = -(T_W'(p_xvx_ff) + T_W'(p_yvy_ff) + T_W'(p_zvz_ff));
   assign t_x_in = T_W'(p_svx_ff) + T_W'(p_yvz_ff) - T_W'(p_zvy_ff);
   assign t_y_in = T_W'(p_svy_ff) + T_W'(p_zvx_ff) - T_W'(p_xvz_ff);
   assign t_z_in = T_W'(p_svz_ff) + T_W'(p_xvy_ff) - T_W'(p_yvx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (rdy_s2) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s2) begin
         s2_zq_ff  <= s1_zq_ff;
         s2_den_ff <= s2_den_in;
         t_s_ff    <= t_s_in;
         t_x_ff    <= t_x_in;
         t_y_ff    <= t_y_in;
         t_z_ff    <= t_z_in;
         s2_qs_ff  <= s1_qs_ff;
         s2_qx_ff  <= s1_qx_ff;
         s2_qy_ff  <= s1_qy_ff;
         s2_qz_ff  <= s1_qz_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: products of t with the parts of conj(q).
   // ---------------------------------------------------------------------
   logic s3_vld_ff;
   logic s3_zq_ff;
   logic [DEN_W-1:0] s3_den_ff;
   logic signed [RP_W-1:0] rx_a_ff, rx_b_ff, rx_c_ff, rx_d_ff;
   logic signed [RP_W-1:0] ry_a_ff, ry_b_ff, ry_c_ff, ry_d_ff;
   logic signed [RP_W-1:0] rz_a_ff, rz_b_ff, rz_c_ff, rz_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (rdy_s3) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s3) begin
         s3_zq_ff  <= s2_zq_ff;
         s3_den_ff <= s2_den_ff;
         rx_a_ff   <= t_s_ff * s2_qx_ff;
         rx_b_ff   <= t_x_ff * s2_qs_ff;
         rx_c_ff   <= t_y_ff * s2_qz_ff;
         rx_d_ff   <= t_z_ff * s2_qy_ff;
         ry_a_ff   <= t_s_ff * s2_qy_ff;
         ry_b_ff   <= t_y_ff * s2_qs_ff;
         ry_c_ff   <= t_z_ff * s2_qx_ff;
         ry_d_ff   <= t_x_ff * s2_qz_ff;
         rz_a_ff   <= t_s_ff * s2_qz_ff;
         rz_b_ff   <= t_z_ff * s2_qs_ff;
         rz_c_ff   <= t_x_ff * s2_qy_ff;
         rz_d_ff   <= t_y_ff * s2_qx_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: vector part of t * conj(q).
   // ---------------------------------------------------------------------
   logic s4_vld_ff;
   logic s4_zq_ff;
   logic [DEN_W-1:0] s4_den_ff;
   logic signed [R_W-1:0] r_ff [LANES];
   logic signed [R_W-1:0] r_in [LANES];

   assign r_in[0] = -R_W'(rx_a_ff) + R_W'(rx_b_ff) - R_W'(rx_c_ff) + R_W'(rx_d_ff);
   assign r_in[1] = -R_W'(ry_a_ff) + R_W'(ry_b_ff) - R_W'(ry_c_ff) + R_W'(ry_d_ff);
   assign r_in[2] = -R_W'(rz_a_ff) + R_W'(rz_b_ff) - R_W'(rz_c_ff) + R_W'(rz_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (rdy_s4) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_s4) begin
         s4_zq_ff  <= s3_zq_ff;
         s4_den_ff <= s3_den_ff;
         r_ff      <= r_in;
      end
   end

   // ---------------------------------------------------------------------
   // Divider. Rounding to nearest with ties away from zero is done by
   // dividing 2*|r| + den by 2*den with truncation. The head register holds
   // that dividend and divisor; the first step also flags quotients of 2^17
   // and up, which saturate whatever the low bits turn out to be. Each
   // following step resolves one quotient bit, most significant first.
   // ---------------------------------------------------------------------
   logic          div_vld_ff [QUO_W+1];
   logic          div_vld_in [QUO_W+1];
   div_stage_type div_ff     [QUO_W+1];
   div_stage_type div_in     [QUO_W+1];

   assign div_vld_in[0] = s4_vld_ff;

   always_comb begin
      logic [R_W-1:0] mag;
      div_in[0].dvs = {s4_den_ff, 1'b0};
      div_in[0].zq  = s4_zq_ff;
      for (int l = 0; l < LANES; l++) begin
         mag = r_ff[l][R_W-1] ? unsigned'(-r_ff[l]) : unsigned'(r_ff[l]);
         div_in[0].lane[l].neg = r_ff[l][R_W-1];
         div_in[0].lane[l].rem = {mag, 1'b0} + NUM_W'(s4_den_ff);
         div_in[0].lane[l].quo = '0;
         div_in[0].lane[l].ovf = 1'b0;
      end
   end

   assign rdy_div[QUO_W] = !div_vld_ff[QUO_W] || rdy_out;

   for (genvar j = 0; j < QUO_W; j++) begin : g_rdy
      assign rdy_div[j] = !div_vld_ff[j] || rdy_div[j+1];
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      localparam int K = QUO_W - j;

      assign div_vld_in[j] = div_vld_ff[j-1];

      always_comb begin
         logic [NUM_W-1:0] trial;
         logic             fits;
         div_in[j] = div_ff[j-1];
         trial     = NUM_W'(div_ff[j-1].dvs) << K;
         for (int l = 0; l < LANES; l++) begin
            fits = div_ff[j-1].lane[l].rem >= trial;
            div_in[j].lane[l].quo[K] = fits;
            if (fits) begin
               div_in[j].lane[l].rem = div_ff[j-1].lane[l].rem - trial;
            end
            if (j == 1) begin
               div_in[j].lane[l].ovf =
                  div_ff[j-1].lane[l].rem >= (NUM_W'(div_ff[j-1].dvs) << QUO_W);
            end
         end
      end
   end

   for (genvar j = 0; j <= QUO_W; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[j] <= 1'b0;
         end else if (rdy_div[j]) begin
            div_vld_ff[j] <= div_vld_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy_div[j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register: sign, saturation and the zero quaternion case.
   // ---------------------------------------------------------------------
   logic    rsp_vld_ff;
   s16_type rot_ff [LANES];
   s16_type rot_in [LANES];
   logic    zq_ff, zq_in;
   logic    sat_ff, sat_in;

   always_comb begin
      logic [QUO_W-1:0] quo;
      logic             clip;
      sat_in = 1'b0;
      zq_in  = div_ff[QUO_W].zq;
      for (int l = 0; l < LANES; l++) begin
         quo = div_ff[QUO_W].lane[l].quo;
         if (div_ff[QUO_W].lane[l].neg) begin
            clip      = div_ff[QUO_W].lane[l].ovf || (quo > NEG_LIMIT);
            rot_in[l] = clip ? NEG_CLIP : -quo[IN_W-1:0];
         end else begin
            clip      = div_ff[QUO_W].lane[l].ovf || (quo > POS_LIMIT);
            rot_in[l] = clip ? POS_CLIP : quo[IN_W-1:0];
         end
         if (zq_in) begin
            rot_in[l] = '0;
         end else begin
            sat_in = sat_in | clip;
         end
      end
   end

   assign rdy_out = !rsp_vld_ff || !rsp_stall;
   assign rdy_s4  = !s4_vld_ff || rdy_div[0];
   assign rdy_s3  = !s3_vld_ff || rdy_s4;
   assign rdy_s2  = !s2_vld_ff || rdy_s3;
   assign rdy_s1  = !s1_vld_ff || rdy_s2;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rdy_out) begin
         rsp_vld_ff <= div_vld_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         rot_ff <= rot_in;
         zq_ff  <= zq_in;
         sat_ff <= sat_in;
      end
   end

   assign req_stall     = !rdy_s1;
   assign rsp_valid     = rsp_vld_ff;
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_zero_quat = zq_ff;
   assign rsp_saturated = sat_ff;

   // A zero quaternion result carries zero components and no clip flag.
   a_zero_quat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_quat) |->
      (rsp_rot_x == '0 && rsp_rot_y == '0 && rsp_rot_z == '0 && !rsp_saturated))
      else $error("zero quaternion result is not cleared");

   // Requests are held off only while the first stage holds an item.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff)
      else $error("request stalled with an empty first stage");

   // A finished quotient waiting behind a stalled output is kept.
   a_div_tail_kept: assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[QUO_W] && !rdy_out) |=> div_vld_ff[QUO_W])
      else $error("divider result lost during output stall");

   // A request that was stalled at the first stage is still there next cycle.
   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !rdy_s2) |=> (s1_vld_ff && $stable(s1_zq_ff)))
      else $error("first stage item lost during stall");

endmodule

FILE: sim/rotation_check.sv
`timescale 1ns / 1ps

module rotation_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  qvr_pkg::s16_type req_quat_s,
   input  qvr_pkg::s16_type req_quat_x,
   input  qvr_pkg::s16_type req_quat_y,
   input  qvr_pkg::s16_type req_quat_z,
   input  qvr_pkg::s16_type req_vec_x,
   input  qvr_pkg::s16_type req_vec_y,
   input  qvr_pkg::s16_type req_vec_z,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  qvr_pkg::s16_type rsp_rot_x,
   input  qvr_pkg::s16_type rsp_rot_y,
   input  qvr_pkg::s16_type rsp_rot_z,
   input  logic             rsp_zero_quat,
   input  logic             rsp_saturated,
   output int               error_count,
   output int               pending_count,
   output int               request_count,
   output int               zero_quat_count,
   output int               saturated_count,
   output int               input_stall_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      qvr_pkg::s16_type x;
      qvr_pkg::s16_type y;
      qvr_pkg::s16_type z;
      logic             zero_quat;
      logic             saturated;
   } rotation_type;

   rotation_type expected_rotations[$];

   int errors        = 0;
   int requests      = 0;
   int responses     = 0;
   int zero_results  = 0;
   int clip_results  = 0;
   int held_requests = 0;

   // Divides by the squared norm, rounding to nearest with ties away from zero,
   // and clips the quotient to the signed 16-bit range.
   function automatic qvr_pkg::s16_type divide_by_norm(input longint num, input longint norm2,
                                                       inout logic clipped);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned quo;
      longint unsigned neg_quo;
      qvr_pkg::s16_type scaled;
      if (num < 0) begin
         mag = -num;
      end else begin
         mag = num;
      end
      den = norm2;
      quo = (2 * mag + den) / (2 * den);
      neg_quo = -quo;
      if (num < 0) begin
         if (quo > 64'd32768) begin
            clipped = 1'b1;
            scaled  = qvr_pkg::NEG_CLIP;
         end else begin
            scaled = neg_quo[15:0];
         end
      end else begin
         if (quo > 64'd32767) begin
            clipped = 1'b1;
            scaled  = qvr_pkg::POS_CLIP;
         end else begin
            scaled = quo[15:0];
         end
      end
      return scaled;
   endfunction

   // Rotates v by q as q * (0, v) * conj(q) / |q|^2, all in exact integers.
   function automatic rotation_type predict_rotation(input qvr_pkg::s16_type qs, qx, qy, qz,
                                                     vx, vy, vz);
      longint s, x, y, z, ax, ay, az;
      longint norm2, ts, tx, ty, tz, rx, ry, rz;
      logic clipped;
      rotation_type res;
      s  = qs;
      x  = qx;
      y  = qy;
      z  = qz;
      ax = vx;
      ay = vy;
      az = vz;
      res = '0;
      clipped = 1'b0;
      norm2 = s * s + x * x + y * y + z * z;
      if (norm2 == 0) begin
         res.zero_quat = 1'b1;
      end else begin
         ts = -(x * ax + y * ay + z * az);
         tx = s * ax + y * az - z * ay;
         ty = s * ay + z * ax - x * az;
         tz = s * az + x * ay - y * ax;
         rx = -ts * x + s * tx - ty * z + tz * y;
         ry = -ts * y + s * ty - tz * x + tx * z;
         rz = -ts * z + s * tz - tx * y + ty * x;
         res.x = divide_by_norm(rx, norm2, clipped);
         res.y = divide_by_norm(ry, norm2, clipped);
         res.z = divide_by_norm(rz, norm2, clipped);
         res.saturated = clipped;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      rotation_type want;
      rotation_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rotations.push_back(predict_rotation(req_quat_s, req_quat_x, req_quat_y,
                                                          req_quat_z, req_vec_x, req_vec_y,
                                                          req_vec_z));
            requests++;
         end
         if (req_valid && req_stall) begin
            held_requests++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.x         = rsp_rot_x;
            got.y         = rsp_rot_y;
            got.z         = rsp_rot_z;
            got.zero_quat = rsp_zero_quat;
            got.saturated = rsp_saturated;
            if (expected_rotations.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("Unexpected response: x=%0d y=%0d z=%0d zero=%0b sat=%0b",
                           got.x, got.y, got.z, got.zero_quat, got.saturated);
               end
            end else begin
               want = expected_rotations.pop_front();
               if (got.x != want.x || got.y != want.y || got.z != want.z ||
                   got.zero_quat != want.zero_quat || got.saturated != want.saturated) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("Mismatch on response %0d:", responses);
                     $display("   expected x=%0d y=%0d z=%0d zero=%0b sat=%0b",
                              want.x, want.y, want.z, want.zero_quat, want.saturated);
                     $display("   actual   x=%0d y=%0d z=%0d zero=%0b sat=%0b",
                              got.x, got.y, got.z, got.zero_quat, got.saturated);
                  end
               end
            end
            if (got.zero_quat) begin
               zero_results++;
            end
            if (got.saturated) begin
               clip_results++;
            end
            responses++;
         end
      end
      error_count       <= errors;
      pending_count     <= expected_rotations.size();
      request_count     <= requests;
      zero_quat_count   <= zero_results;
      saturated_count   <= clip_results;
      input_stall_count <= held_requests;
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   // About 1700 requests in all: a directed set first, then random ones.
   localparam int RANDOM_REQUESTS  = 1680;
   // The sender stops once in the random part and waits for the pipeline to drain.
   localparam int DRAIN_PAUSE_AT   = 800;
   // The receiver stops once for this long after a few hundred requests, so the
   // 23-stage pipeline fills up and the block has to stall its input.
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_REQS  = 400;
   // A settling margin, waited out after the last response.
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 400000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   qvr_pkg::s16_type req_quat_s;
   qvr_pkg::s16_type req_quat_x;
   qvr_pkg::s16_type req_quat_y;
   qvr_pkg::s16_type req_quat_z;
   qvr_pkg::s16_type req_vec_x;
   qvr_pkg::s16_type req_vec_y;
   qvr_pkg::s16_type req_vec_z;
   logic             rsp_valid;
   logic             rsp_stall;
   qvr_pkg::s16_type rsp_rot_x;
   qvr_pkg::s16_type rsp_rot_y;
   qvr_pkg::s16_type rsp_rot_z;
   logic             rsp_zero_quat;
   logic             rsp_saturated;

   int error_count;
   int pending_count;
   int request_count;
   int zero_quat_count;
   int saturated_count;
   int input_stall_count;
   int cycle_count;
   int burst_left;

   quaternion_vector_rotate_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_quat_s    (req_quat_s),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rot_x     (rsp_rot_x),
      .rsp_rot_y     (rsp_rot_y),
      .rsp_rot_z     (rsp_rot_z),
      .rsp_zero_quat (rsp_zero_quat),
      .rsp_saturated (rsp_saturated)
   );

   // The checker sits beside the block, predicts every rotation from the
   // accepted requests and compares the responses in order.
   rotation_check i_rotation_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_quat_s        (req_quat_s),
      .req_quat_x        (req_quat_x),
      .req_quat_y        (req_quat_y),
      .req_quat_z        (req_quat_z),
      .req_vec_x         (req_vec_x),
      .req_vec_y         (req_vec_y),
      .req_vec_z         (req_vec_z),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_rot_x         (rsp_rot_x),
      .rsp_rot_y         (rsp_rot_y),
      .rsp_rot_z         (rsp_rot_z),
      .rsp_zero_quat     (rsp_zero_quat),
      .rsp_saturated     (rsp_saturated),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .request_count     (request_count),
      .zero_quat_count   (zero_quat_count),
      .saturated_count   (saturated_count),
      .input_stall_count (input_stall_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The run is cut off at a cycle limit that lies far beyond the slowest
   // correct run, so a hung handshake ends as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Gap after an accepted request. Most gaps are zero or short and a few are
   // long; now and then a burst of back-to-back requests goes out with no gap.
   function automatic int pick_gap();
      int r;
      int gap;
      r = $urandom_range(0, 99);
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if (r < 3) begin
         burst_left = $urandom_range(20, 60);
      end else if (r < 55) begin
         gap = 0;
      end else if (r < 88) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 12);
      end else begin
         gap = $urandom_range(20, 80);
      end
      return gap;
   endfunction

   // A vector component: mostly any 16-bit value, sometimes one of the corners or 0, 1 or -1.
   function automatic qvr_pkg::s16_type pick_component();
      qvr_pkg::s16_type v;
      case ($urandom_range(0, 19))
         0:       v = 16'h8000;
         1:       v = 16'h7FFF;
         2:       v = 16'h0000;
         3:       v = 16'hFFFF;
         4:       v = 16'h0001;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // A quaternion from one of several families. Some are zero; tiny quaternions give small
   // divisors and so many rounding ties; parts within plus or minus Q1.14 one are the usual
   // rotations; the rest span the whole 16-bit range, corners included.
   task automatic pick_quaternion(output qvr_pkg::s16_type qs, qx, qy, qz);
      int family;
      family = $urandom_range(0, 99);
      if (family < 6) begin
         qs = '0;
         qx = '0;
         qy = '0;
         qz = '0;
      end else if (family < 25) begin
         qs = 16'(int'($urandom_range(0, 8)) - 4);
         qx = 16'(int'($urandom_range(0, 8)) - 4);
         qy = 16'(int'($urandom_range(0, 8)) - 4);
         qz = 16'(int'($urandom_range(0, 8)) - 4);
      end else if (family < 60) begin
         qs = 16'(int'($urandom_range(0, 32768)) - 16384);
         qx = 16'(int'($urandom_range(0, 32768)) - 16384);
         qy = 16'(int'($urandom_range(0, 32768)) - 16384);
         qz = 16'(int'($urandom_range(0, 32768)) - 16384);
      end else begin
         qs = pick_component();
         qx = pick_component();
         qy = pick_component();
         qz = pick_component();
      end
   endtask

   // Offers one request and holds it steady until the block takes it. Valid
   // stays high into the next request when the gap is zero.
   task automatic send_request(input qvr_pkg::s16_type qs, qx, qy, qz, vx, vy, vz);
      int gap;
      req_valid  <= 1'b1;
      req_quat_s <= qs;
      req_quat_x <= qx;
      req_quat_y <= qy;
      req_quat_z <= qz;
      req_vec_x  <= vx;
      req_vec_y  <= vy;
      req_vec_z  <= vz;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side back-pressure. Runs of free flow, random flicker, short holds
   // and the odd long hold alternate, and once the receiver holds off long
   // enough for the pipeline to back up into the request side.
   initial begin : result_backpressure
      int mode;
      int span;
      bit long_hold_done;
      long_hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!long_hold_done && request_count >= HOLD_AFTER_REQS) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 99);
         if (mode < 40) begin
            span = $urandom_range(1, 40);
            rsp_stall <= 1'b0;
            repeat (span) @(posedge clock);
         end else if (mode < 85) begin
            span = $urandom_range(1, 20);
            repeat (span) begin
               rsp_stall <= 1'($urandom_range(0, 1));
               @(posedge clock);
            end
         end else if (mode < 97) begin
            span = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end else begin
            span = $urandom_range(30, 120);
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : request_stimulus
      qvr_pkg::s16_type qs, qx, qy, qz;
      burst_left = 0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_quat_s <= '0;
      req_quat_x <= '0;
      req_quat_y <= '0;
      req_quat_z <= '0;
      req_vec_x  <= '0;
      req_vec_y  <= '0;
      req_vec_z  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero quaternion: no rotation is defined, the flag is raised and the
      // result is zero whatever the vector holds.
      send_request(0, 0, 0, 0, 32767, -32768, 12345);
      send_request(0, 0, 0, 0, 0, 0, 0);
      // Identity in both signs and at the most negative scalar.
      send_request(16384, 0, 0, 0, 32767, -32768, 1);
      send_request(-16384, 0, 0, 0, -32768, -32768, -32768);
      send_request(-32768, 0, 0, 0, 32767, 32767, -1);
      send_request(-1, 0, 0, 0, -1, 1, 0);
      // Quarter turns about each axis.
      send_request(11585, 11585, 0, 0, 100, 200, -300);
      send_request(11585, 0, 11585, 0, -32768, 32767, 0);
      send_request(11585, 0, 0, 11585, 32767, 0, -1);
      // Half turns about z and about x: negating -32768 has to clip.
      send_request(0, 0, 0, 16384, -32768, 5, 7);
      send_request(0, 16384, 0, 0, 1, -32768, 32767);
      // Unnormalized quaternions: the scale of q drops out.
      send_request(1, 0, 0, 0, 32767, -32768, 32767);
      send_request(0, 1, 0, 0, -32768, 32767, -32768);
      send_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
      send_request(32767, 32767, 32767, 32767, -32768, -32768, -32768);
      send_request(32767, -32768, 32767, -32768, 32767, -32768, 32767);
      // An eighth turn about z stretches the diagonal vector past full scale.
      send_request(15137, 0, 0, 6270, 32767, 32767, 32767);
      send_request(15137, 0, 0, 6270, -32768, -32768, -32768);
      // Small divisors, where rounding ties show up.
      send_request(3, 1, 0, 0, 0, 1, 1);
      send_request(1, 1, 1, 0, -1, 2, 3);
      send_request(2, -1, 1, 1, 5, -3, 7);
      send_request(1, 1, 1, 1, 32767, 0, -32768);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == DRAIN_PAUSE_AT) begin
            // Let the pipeline run dry before carrying on.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) begin
               @(posedge clock);
            end
         end
         pick_quaternion(qs, qx, qy, qz);
         send_request(qs, qx, qy, qz, pick_component(), pick_component(), pick_component());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Rotated %0d vectors: %0d with a zero quaternion, %0d with clipped components.",
               request_count, zero_quat_count, saturated_count);
      $display("Requests were held back by the block for %0d cycles.", input_stall_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_unit.sv
sim/rotation_check.sv
sim/tb_top.sv
